// ===== hw/rtl/pdls_pkg.sv =====
// Shared types, constants and helpers of the directional-light Phong shader.
package pdls_pkg;

  // Fixed-point constants
  localparam logic [14:0] OneQ14 = 15'd16384;
  localparam logic [14:0] KsQ16  = 15'd19661;  // specular strength 0.3 in Q0.16

  // Back pipeline step counts
  localparam int SqrtSteps = 30;  // root bits of |ray| in Q.14
  localparam int DivSteps  = 14;  // cosine quotient bits below 1.0
  localparam int PowSteps  = 8;   // exponent bits

  // Register indexes
  typedef enum logic [2:0] {
    REG_LIGHT_DIR_X = 3'd0,
    REG_LIGHT_DIR_Y = 3'd1,
    REG_LIGHT_DIR_Z = 3'd2,
    REG_LIGHT_RED   = 3'd3,
    REG_LIGHT_GREEN = 3'd4,
    REG_LIGHT_BLUE  = 3'd5,
    REG_AMBIENT     = 3'd6,
    REG_NONE        = 3'd7
  } reg_idx_e;

  localparam logic [15:0] RstLightDirX = 16'd0;
  localparam logic [15:0] RstLightDirY = 16'd16384;
  localparam logic [15:0] RstLightDirZ = 16'd0;
  localparam logic [15:0] RstColor     = 16'd4096;
  localparam logic [15:0] RstAmbient   = 16'd6554;

  typedef struct packed {
    logic signed [15:0] ray_x;
    logic signed [15:0] ray_y;
    logic signed [15:0] ray_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [7:0]         shininess;
    logic               shadowed;
  } in_t;

  typedef struct packed {
    logic [17:0] out_red;
    logic [17:0] out_green;
    logic [17:0] out_blue;
  } out_t;

  typedef struct packed {
    logic signed [15:0] light_dir_x;
    logic signed [15:0] light_dir_y;
    logic signed [15:0] light_dir_z;
    logic [15:0]        light_red;
    logic [15:0]        light_green;
    logic [15:0]        light_blue;
    logic [15:0]        ambient_gain;
  } cfg_t;

  // Request handed from the front to the back
  typedef struct packed {
    logic               shadowed;
    logic [7:0]         shininess;
    logic [14:0]        kd;
    logic signed [41:0] t;   // -(ray . reflect), Q.14
    logic [31:0]        rr;  // ray . ray
  } job_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Q1.14 product, rounded half up
  function automatic logic [14:0] mul_q14(input logic [14:0] a, input logic [14:0] b);
    logic [29:0] p;
    p = 30'(a) * 30'(b);
    return 15'((p + 30'd8192) >> 14);
  endfunction

endpackage

// ===== hw/rtl/pdls_front.sv =====
// Front: dot products, diffuse term and reflected light vector per request.
module pdls_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pdls_pkg::in_t       in_req_i,
  input  pdls_pkg::cfg_t      cfg_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output pdls_pkg::job_t      job_o
);

  logic en;
  logic v1_q, v2_q, v3_q;

  // stage 1 payload
  logic signed [34:0] nl_q;
  logic [31:0]        rr1_q;
  pdls_pkg::in_t      it1_q;
  // stage 2 payload
  logic signed [21:0] rf_x_q, rf_y_q, rf_z_q;
  logic [14:0]        kd2_q;
  logic [31:0]        rr2_q;
  pdls_pkg::in_t      it2_q;
  // stage 3 payload
  pdls_pkg::job_t     job_q;

  logic signed [34:0] nl_d;
  logic signed [32:0] rr_d;
  logic signed [20:0] d;
  logic [14:0]        kd_d;
  logic signed [36:0] s_x, s_y, s_z;
  logic signed [41:0] rdot;

  // pipeline moves unless the last stage is stuck
  assign en          = !v3_q || job_ready_i;
  assign in_ready_o  = en;
  assign job_valid_o = v3_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 1: n.L and ray.ray
  always_comb begin
    nl_d = 35'(in_req_i.normal_x) * 35'(cfg_i.light_dir_x)
         + 35'(in_req_i.normal_y) * 35'(cfg_i.light_dir_y)
         + 35'(in_req_i.normal_z) * 35'(cfg_i.light_dir_z);
    rr_d = 33'(in_req_i.ray_x) * 33'(in_req_i.ray_x)
         + 33'(in_req_i.ray_y) * 33'(in_req_i.ray_y)
         + 33'(in_req_i.ray_z) * 33'(in_req_i.ray_z);
  end

  // stage 2: diffuse clamp and R = -L + 2 d n
  always_comb begin
    d    = 21'(nl_q >>> 14);
    if (d < 0)                       kd_d = '0;
    else if (d > $signed({6'd0, pdls_pkg::OneQ14})) kd_d = pdls_pkg::OneQ14;
    else                             kd_d = d[14:0];
    s_x = -(37'(cfg_i.light_dir_x) <<< 14) + ((37'(d) * 37'(it1_q.normal_x)) <<< 1);
    s_y = -(37'(cfg_i.light_dir_y) <<< 14) + ((37'(d) * 37'(it1_q.normal_y)) <<< 1);
    s_z = -(37'(cfg_i.light_dir_z) <<< 14) + ((37'(d) * 37'(it1_q.normal_z)) <<< 1);
  end

  // stage 3: ray . R
  always_comb begin
    rdot = 42'(it2_q.ray_x) * 42'(rf_x_q)
         + 42'(it2_q.ray_y) * 42'(rf_y_q)
         + 42'(it2_q.ray_z) * 42'(rf_z_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nl_q  <= nl_d;
      rr1_q <= rr_d[31:0];
      it1_q <= in_req_i;
      rf_x_q <= 22'(s_x >>> 14);
      rf_y_q <= 22'(s_y >>> 14);
      rf_z_q <= 22'(s_z >>> 14);
      kd2_q <= kd_d;
      rr2_q <= rr1_q;
      it2_q <= it1_q;
      job_q.shadowed  <= it2_q.shadowed;
      job_q.shininess <= it2_q.shininess;
      job_q.kd        <= kd2_q;
      job_q.t         <= -rdot;
      job_q.rr        <= rr2_q;
    end
  end

endmodule

// ===== hw/rtl/pdls_queue.sv =====
// Small request queue between front and back.
module pdls_queue #(
  parameter int Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pdls_pkg::job_t     push_data_i,
  input  logic               pop_i,
  output pdls_pkg::job_t     head_o,
  output pdls_pkg::q_stat_t  stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pdls_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/pdls_back.sv =====
// Back: |ray| square root, cosine divide, power, gain and color scaling.
module pdls_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  pdls_pkg::job_t   job_i,
  input  pdls_pkg::cfg_t   cfg_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pdls_pkg::out_t   out_rsp_o
);

  localparam int Sq   = pdls_pkg::SqrtSteps;
  localparam int Dv   = pdls_pkg::DivSteps;
  localparam int Pw   = pdls_pkg::PowSteps;
  localparam int CmpS = Sq;
  localparam int DivE = Sq + 1 + Dv;
  localparam int PowE = DivE + Pw;
  localparam int NSt  = PowE + 1;

  typedef struct packed {
    logic               shadowed;
    logic [7:0]         shin;
    logic [14:0]        kd;
    logic signed [41:0] t;
    logic [31:0]        rr;
    logic [33:0]        rem;
    logic [29:0]        root;
    logic               sat;
    logic [13:0]        q;
    logic [14:0]        acc;
    logic [14:0]        base;
    logic [17:0]        gain;
  } bk_t;

  bk_t             st_q [NSt];
  logic [NSt-1:0]  v_q;
  bk_t             init;
  logic            en;
  logic            out_v_q;
  pdls_pkg::out_t  out_q;

  assign en          = !out_v_q || out_ready_i;
  assign job_ready_o = en;
  assign out_valid_o = out_v_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    init          = '0;
    init.shadowed = job_i.shadowed;
    init.shin     = job_i.shininess;
    init.kd       = job_i.kd;
    init.t        = job_i.t;
    init.rr       = job_i.rr;
  end

  for (genvar k = 0; k < NSt; k++) begin : g_st
    bk_t p, n;

    if (k == 0) begin : g_first
      assign p = init;
    end else begin : g_rest
      assign p = st_q[k-1];
    end

    if (k < Sq) begin : g_sqrt
      // one root bit of sqrt(rr * 2^28) per stage
      localparam int B = 2 * (Sq - 1 - k) - 28;
      logic [1:0]  bits;
      logic [33:0] r4, trial;
      logic        ge;
      if (B >= 0) begin : g_bits
        assign bits = p.rr[B+1:B];
      end else begin : g_zero
        assign bits = 2'b00;
      end
      always_comb begin
        r4     = {p.rem[31:0], bits};
        trial  = {2'b00, p.root, 2'b01};
        ge     = (r4 >= trial);
        n      = p;
        n.rem  = ge ? (r4 - trial) : r4;
        n.root = {p.root[28:0], ge};
      end
    end else if (k == CmpS) begin : g_cmp
      // back-facing gives 0, t >= |ray| saturates to 1.0
      logic pos, sat;
      always_comb begin
        pos   = !p.t[41] && (p.t != '0);
        sat   = pos && (p.t >= $signed({12'd0, p.root}));
        n     = p;
        n.sat = sat;
        n.rem = (pos && !sat) ? {4'd0, p.t[29:0]} : '0;
        n.q   = '0;
      end
    end else if (k < DivE) begin : g_div
      // restoring divide, one quotient bit per stage
      logic [33:0] r2;
      logic        ge;
      always_comb begin
        r2    = {p.rem[32:0], 1'b0};
        ge    = (r2 >= {4'd0, p.root});
        n     = p;
        n.rem = ge ? (r2 - {4'd0, p.root}) : r2;
        n.q   = {p.q[12:0], ge};
      end
    end else if (k < PowE) begin : g_pow
      // square and multiply, exponent bit J
      localparam int J = k - DivE;
      logic [14:0] a_in, b_in;
      if (J == 0) begin : g_seed
        assign a_in = pdls_pkg::OneQ14;
        assign b_in = p.sat ? pdls_pkg::OneQ14 : {1'b0, p.q};
      end else begin : g_chain
        assign a_in = p.acc;
        assign b_in = p.base;
      end
      always_comb begin
        n      = p;
        n.acc  = p.shin[J] ? pdls_pkg::mul_q14(a_in, b_in) : a_in;
        n.base = pdls_pkg::mul_q14(b_in, b_in);
      end
    end else begin : g_gain
      // gain = ka + 4 kd + 0.3 spec, Q.16; zero ray has no specular
      logic [14:0] spec;
      logic [31:0] ks;
      always_comb begin
        spec   = (p.rr == '0) ? '0 : p.acc;
        ks     = 32'(spec) * 32'(pdls_pkg::KsQ16);
        n      = p;
        n.gain = 18'(cfg_i.ambient_gain) + 18'({p.kd, 2'b00}) + 18'(ks >> 14);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        if (k == 0) v_q[k] <= job_valid_i;
        else        v_q[k] <= v_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) st_q[k] <= n;
    end
  end

  // output register: color * gain >> 16; 34-bit product keeps it within 18 bits
  logic [33:0] pr, pg, pb;
  bk_t         lst;
  assign lst = st_q[NSt-1];
  assign pr  = 34'(cfg_i.light_red)   * 34'(lst.gain);
  assign pg  = 34'(cfg_i.light_green) * 34'(lst.gain);
  assign pb  = 34'(cfg_i.light_blue)  * 34'(lst.gain);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v_q[NSt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.out_red   <= lst.shadowed ? '0 : pr[33:16];
      out_q.out_green <= lst.shadowed ? '0 : pg[33:16];
      out_q.out_blue  <= lst.shadowed ? '0 : pb[33:16];
    end
  end

endmodule

// ===== hw/rtl/phong_directional_light_shade_top.sv =====
// Top level of the directional-light Phong shader: config registers, front, queue, back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  input    | in_valid_i/in_ready_o | in_req_i  (pdls_pkg::in_t)
//  output   | out_valid_o/out_ready_i | out_rsp_o (pdls_pkg::out_t)
//  config   | APB psel/penable      | paddr, pwdata, prdata
//
// One request per cycle sustained while the output is not stalled. A request
// passes the front, the queue and the back, which holds the 30-step square root,
// 14-step divide and 8-step power stages. Reset clears all valid flags and
// restores the registers. A stalled output freezes the back; the queue lets the
// front keep accepting until it fills, then in_ready_o drops.
module phong_directional_light_shade_top #(
  parameter int QueueDepth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pdls_pkg::in_t    in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pdls_pkg::out_t   out_rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  pdls_pkg::cfg_t    cfg_q;
  pdls_pkg::reg_idx_e idx;
  pdls_pkg::job_t    f_job, q_head;
  pdls_pkg::q_stat_t q_stat;
  logic              f_valid, q_ready, b_ready;

  assign pready = 1'b1;
  assign idx    = pdls_pkg::reg_idx_e'(paddr[4:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_dir_x  <= pdls_pkg::RstLightDirX;
      cfg_q.light_dir_y  <= pdls_pkg::RstLightDirY;
      cfg_q.light_dir_z  <= pdls_pkg::RstLightDirZ;
      cfg_q.light_red    <= pdls_pkg::RstColor;
      cfg_q.light_green  <= pdls_pkg::RstColor;
      cfg_q.light_blue   <= pdls_pkg::RstColor;
      cfg_q.ambient_gain <= pdls_pkg::RstAmbient;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        pdls_pkg::REG_LIGHT_DIR_X: cfg_q.light_dir_x  <= pwdata[15:0];
        pdls_pkg::REG_LIGHT_DIR_Y: cfg_q.light_dir_y  <= pwdata[15:0];
        pdls_pkg::REG_LIGHT_DIR_Z: cfg_q.light_dir_z  <= pwdata[15:0];
        pdls_pkg::REG_LIGHT_RED:   cfg_q.light_red    <= pwdata[15:0];
        pdls_pkg::REG_LIGHT_GREEN: cfg_q.light_green  <= pwdata[15:0];
        pdls_pkg::REG_LIGHT_BLUE:  cfg_q.light_blue   <= pwdata[15:0];
        pdls_pkg::REG_AMBIENT:     cfg_q.ambient_gain <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (idx)
      pdls_pkg::REG_LIGHT_DIR_X: prdata = {16'd0, cfg_q.light_dir_x};
      pdls_pkg::REG_LIGHT_DIR_Y: prdata = {16'd0, cfg_q.light_dir_y};
      pdls_pkg::REG_LIGHT_DIR_Z: prdata = {16'd0, cfg_q.light_dir_z};
      pdls_pkg::REG_LIGHT_RED:   prdata = {16'd0, cfg_q.light_red};
      pdls_pkg::REG_LIGHT_GREEN: prdata = {16'd0, cfg_q.light_green};
      pdls_pkg::REG_LIGHT_BLUE:  prdata = {16'd0, cfg_q.light_blue};
      pdls_pkg::REG_AMBIENT:     prdata = {16'd0, cfg_q.ambient_gain};
      default:                   prdata = '0;
    endcase
  end

  pdls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cfg_i       (cfg_q),
    .job_valid_o (f_valid),
    .job_ready_i (q_ready),
    .job_o       (f_job)
  );

  assign q_ready = !q_stat.full;

  pdls_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_valid),
    .push_data_i (f_job),
    .pop_i       (b_ready),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  pdls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_stat.empty),
    .job_ready_o (b_ready),
    .job_i       (q_head),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // queue can never be both full and empty
  a_q_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  // a head the back did not take stays at the head
  a_q_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_stat.empty && !b_ready) |=> (!q_stat.empty && $stable(q_head)))
    else $error("queue head changed without pop");

  // a front request that the full queue does not take stays offered
  a_f_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && !q_ready) |=> f_valid)
    else $error("front request dropped while queue full");

endmodule

// ===== tb/pdls_shade_checker.sv =====
// Checker of the directional-light Phong shader: predicts each shade result and compares.
`timescale 1ns / 100ps

module pdls_shade_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  pdls_pkg::in_t  in_req_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  pdls_pkg::out_t out_rsp_i,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  input  logic           pready,
  output int             fail_count_o,
  output int             pending_o
);

  pdls_pkg::cfg_t light_cfg;
  pdls_pkg::out_t shade_q[$];

  // Integer square root, bit by bit
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clamp_one(longint x);
    if (x < 0) return 0;
    if (x > longint'(pdls_pkg::OneQ14)) return longint'(pdls_pkg::OneQ14);
    return x;
  endfunction

  // Expected color of one hit point under the current light
  function automatic pdls_pkg::out_t shade_expect(pdls_pkg::in_t q, pdls_pkg::cfg_t c);
    longint ray[3], nrm[3], lgt[3], refl[3];
    longint nl, rr, rdot, kd, d, t, cosv, acc, base, spec, gain;
    longint unsigned m, v;
    logic [15:0] col[3];
    logic [17:0] o[3];
    pdls_pkg::out_t r;
    if (q.shadowed) return '0;
    ray[0] = longint'(q.ray_x);    ray[1] = longint'(q.ray_y);
    ray[2] = longint'(q.ray_z);
    nrm[0] = longint'(q.normal_x); nrm[1] = longint'(q.normal_y);
    nrm[2] = longint'(q.normal_z);
    lgt[0] = longint'(c.light_dir_x); lgt[1] = longint'(c.light_dir_y);
    lgt[2] = longint'(c.light_dir_z);
    col[0] = c.light_red; col[1] = c.light_green; col[2] = c.light_blue;
    nl = 0; rr = 0; rdot = 0; spec = 0;
    for (int i = 0; i < 3; i++) begin
      nl += nrm[i] * lgt[i];
      rr += ray[i] * ray[i];
    end
    d  = nl >>> 14;
    kd = clamp_one(d);
    for (int i = 0; i < 3; i++) begin
      refl[i] = (-lgt[i] * 16384 + 2 * d * nrm[i]) >>> 14;
      rdot += ray[i] * refl[i];
    end
    if (rr != 0) begin
      t = -rdot;
      cosv = 0;
      if (t > 0) begin
        m = root64(longint'(rr) << 28);
        cosv = clamp_one(longint'((longint'(t) << 14) / m));
      end
      // square and multiply, low exponent bit first
      acc = longint'(pdls_pkg::OneQ14);
      base = cosv;
      for (int k = 0; k < 8; k++) begin
        if (q.shininess[k]) acc = (acc * base + 8192) >> 14;
        base = (base * base + 8192) >> 14;
      end
      spec = acc;
    end
    gain = longint'(c.ambient_gain) + 4 * kd + ((longint'(pdls_pkg::KsQ16) * spec) >> 14);
    for (int i = 0; i < 3; i++) begin
      v = (longint'(col[i]) * gain) >> 16;
      o[i] = (v > 262143) ? 18'h3ffff : v[17:0];
    end
    r.out_red = o[0];
    r.out_green = o[1];
    r.out_blue = o[2];
    return r;
  endfunction

  // Track register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_cfg <= {pdls_pkg::RstLightDirX, pdls_pkg::RstLightDirY, pdls_pkg::RstLightDirZ,
                    pdls_pkg::RstColor, pdls_pkg::RstColor, pdls_pkg::RstColor,
                    pdls_pkg::RstAmbient};
    end else if (psel && penable && pwrite && pready) begin
      case (pdls_pkg::reg_idx_e'(paddr[4:2]))
        pdls_pkg::REG_LIGHT_DIR_X: light_cfg.light_dir_x  <= pwdata[15:0];
        pdls_pkg::REG_LIGHT_DIR_Y: light_cfg.light_dir_y  <= pwdata[15:0];
        pdls_pkg::REG_LIGHT_DIR_Z: light_cfg.light_dir_z  <= pwdata[15:0];
        pdls_pkg::REG_LIGHT_RED:   light_cfg.light_red    <= pwdata[15:0];
        pdls_pkg::REG_LIGHT_GREEN: light_cfg.light_green  <= pwdata[15:0];
        pdls_pkg::REG_LIGHT_BLUE:  light_cfg.light_blue   <= pwdata[15:0];
        pdls_pkg::REG_AMBIENT:     light_cfg.ambient_gain <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  // Predict on request, compare on result
  always @(posedge clk_i) begin
    pdls_pkg::out_t exp_rsp;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) shade_q.push_back(shade_expect(in_req_i, light_cfg));
      if (out_valid_i && out_ready_i) begin
        if (shade_q.size() == 0) begin
          $error("unexpected result %h", out_rsp_i);
          fail_count_o++;
        end else begin
          exp_rsp = shade_q.pop_front();
          if (exp_rsp.out_red !== out_rsp_i.out_red) begin
            $error("out_red: expected %0d, got %0d", exp_rsp.out_red, out_rsp_i.out_red);
            fail_count_o++;
          end
          if (exp_rsp.out_green !== out_rsp_i.out_green) begin
            $error("out_green: expected %0d, got %0d", exp_rsp.out_green,
                   out_rsp_i.out_green);
            fail_count_o++;
          end
          if (exp_rsp.out_blue !== out_rsp_i.out_blue) begin
            $error("out_blue: expected %0d, got %0d", exp_rsp.out_blue, out_rsp_i.out_blue);
            fail_count_o++;
          end
        end
      end
      pending_o = shade_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the shader testbench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 100ps

module testbench;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  pdls_pkg::in_t  in_req_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  pdls_pkg::out_t out_rsp_o;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [4:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;
  int             fail_count;
  int             pending;

  int send_idle_pct = 11;
  int recv_idle_pct = 49;
  logic hold_go = 1'b0;
  logic hold_used = 1'b0;
  int hold_left = 0;

  always #2 clk_i = ~clk_i;

  phong_directional_light_shade_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i, .out_valid_o, .out_ready_i,
    .out_rsp_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pdls_shade_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_rsp_i(out_rsp_o), .psel, .penable,
    .pwrite, .paddr, .pwdata, .pready, .fail_count_o(fail_count), .pending_o(pending)
  );

  // Result side: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= 300;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one request, return right after the edge that takes it
  task automatic send_hit(input pdls_pkg::in_t hit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= hit;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic reg_write(input pdls_pkg::reg_idx_e idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_light(input logic [15:0] lx, ly, lz, cr, cg, cb, ka);
    reg_write(pdls_pkg::REG_LIGHT_DIR_X, lx);
    reg_write(pdls_pkg::REG_LIGHT_DIR_Y, ly);
    reg_write(pdls_pkg::REG_LIGHT_DIR_Z, lz);
    reg_write(pdls_pkg::REG_LIGHT_RED, cr);
    reg_write(pdls_pkg::REG_LIGHT_GREEN, cg);
    reg_write(pdls_pkg::REG_LIGHT_BLUE, cb);
    reg_write(pdls_pkg::REG_AMBIENT, ka);
  endtask

  function automatic logic [15:0] rand_unit_comp();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic pdls_pkg::in_t make_hit(input logic [15:0] rx, ry, rz, nx, ny, nz,
                                             input logic [7:0] sh, input logic sd);
    pdls_pkg::in_t h;
    h.ray_x = rx; h.ray_y = ry; h.ray_z = rz;
    h.normal_x = nx; h.normal_y = ny; h.normal_z = nz;
    h.shininess = sh; h.shadowed = sd;
    return h;
  endfunction

  // Random hit: mostly lit, axis or random normals, a few zero rays
  function automatic pdls_pkg::in_t rand_hit();
    pdls_pkg::in_t h;
    h = make_hit(16'($urandom), 16'($urandom), 16'($urandom), rand_unit_comp(),
                 rand_unit_comp(), rand_unit_comp(), 8'($urandom),
                 ($urandom_range(99) < 12));
    case ($urandom_range(9))
      0: begin
        h.ray_x = '0; h.ray_y = '0; h.ray_z = '0;
      end
      1, 2: begin
        h.normal_x = '0; h.normal_y = 16'sd16384; h.normal_z = '0;
      end
      3: h.shininess = 8'($urandom_range(4));
      default: ;
    endcase
    return h;
  endfunction

  task automatic random_hits(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 11;
      end else if (i == 2 * n / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_hit(rand_hit());
    end
    send_idle_pct = 11;
    recv_idle_pct = 49;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, shadow, zero ray, zero shininess, back-facing reflection
    send_hit(make_hit(16'd0, -16'sd16384, 16'd0, 16'd0, 16'd16384, 16'd0, 8'd8, 1'b0));
    send_hit(make_hit(16'd0, -16'sd16384, 16'd0, 16'd0, 16'd16384, 16'd0, 8'd8, 1'b1));
    send_hit(make_hit(16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 8'd0, 1'b0));
    send_hit(make_hit(16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 8'd255, 1'b0));
    send_hit(make_hit(16'd5, 16'd7, 16'd0, 16'd16384, 16'd0, 16'd0, 8'd0, 1'b0));
    send_hit(make_hit(16'd0, 16'd1000, 16'd0, 16'd0, 16'd16384, 16'd0, 8'd3, 1'b0));
    send_hit(make_hit(16'h8000, 16'h8000, 16'h8000, -16'sd16384, -16'sd16384,
                      -16'sd16384, 8'd255, 1'b0));
    send_hit(make_hit(16'h7fff, 16'h7fff, 16'h7fff, 16'd16384, 16'd16384, 16'd16384,
                      8'd1, 1'b0));
    send_hit(make_hit(16'h7fff, 16'h8000, 16'h0001, 16'd0, -16'sd16384, 16'd0, 8'd128,
                      1'b0));
    send_hit(make_hit(16'hffff, 16'hffff, 16'hffff, 16'd11585, 16'd11585, 16'd0, 8'd2,
                      1'b1));
    send_hit(make_hit(16'd100, -16'sd100, 16'd0, 16'd0, 16'd16384, 16'd0, 8'd1, 1'b0));
    send_hit(make_hit(16'd0, -16'sd1, 16'd0, 16'd0, 16'd16384, 16'd0, 8'd255, 1'b0));
    drop_valid();
    wait_drained();

    // Extreme light: full colors, full ambient, light along -x
    set_light(-16'sd16384, 16'd0, 16'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    reg_write(pdls_pkg::REG_NONE, 16'h1234);
    send_hit(make_hit(16'd1, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 8'd0, 1'b0));
    send_hit(make_hit(16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 8'd0, 1'b0));
    random_hits(60);
    drop_valid();
    wait_drained();

    // Dark light, zero ambient, light along +z; long result hold-off here
    set_light(16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd0);
    hold_go = 1'b1;
    random_hits(110);
    drop_valid();
    wait_drained();

    // Slanted light, mixed colors; sender pauses for a full drain midway
    set_light(16'd9459, 16'd9459, -16'sd9459, 16'd4096, 16'd20000, 16'd65000, 16'd3000);
    random_hits(60);
    drop_valid();
    wait_drained();
    random_hits(60);
    drop_valid();
    wait_drained();

    // Light along -y, negative extremes of the direction range
    set_light(16'd0, -16'sd16384, 16'd0, 16'd12000, 16'd300, 16'd40000, 16'd32768);
    random_hits(120);
    drop_valid();
    wait_drained();

    // Back to reset-like values
    set_light(16'd0, 16'd16384, 16'd0, 16'd4096, 16'd4096, 16'd4096, 16'd6554);
    random_hits(120);
    drop_valid();
    wait_drained();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== phong_directional_light_shade_top.f =====
hw/rtl/pdls_pkg.sv
hw/rtl/pdls_front.sv
hw/rtl/pdls_queue.sv
hw/rtl/pdls_back.sv
hw/rtl/phong_directional_light_shade_top.sv
tb/pdls_shade_checker.sv
tb/testbench.sv
